@@ hdl/tpdc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpdc_pkg: shared types and constants of the throttle pulse drive controller
// Window sizes, field widths, register codes, reset values and the structs
// passed between the front end, the queue, the back end and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package tpdc_pkg;

    // window sizes
    localparam int THROTTLE_TAPS = 10;
    localparam int ROTOR_TAPS    = 10;

    // field widths
    localparam int TIME_W     = 32;
    localparam int SAMPLE_W   = 10;
    localparam int LEVEL_W    = 11;
    localparam int FORCED_W   = 16;
    localparam int RATE_W     = 12;
    localparam int INTERVAL_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

    // derived widths of the windows
    localparam int SUM_W   = $clog2(SAMPLE_MAX * THROTTLE_TAPS + 1);
    localparam int THR_AW  = (THROTTLE_TAPS > 1) ? $clog2(THROTTLE_TAPS) : 1;
    localparam int ROT_AW  = (ROTOR_TAPS > 1) ? $clog2(ROTOR_TAPS) : 1;
    localparam int ROT_CW  = $clog2(ROTOR_TAPS + 1);

    // level scale and interval constants
    localparam int LEVEL_SHIFT   = 10;
    localparam int LEVEL_MAX     = 1 << LEVEL_SHIFT;
    localparam int INTERVAL_NUM  = 20 * 1024 * 1024;
    localparam int INTERVAL_MAX  = (1 << INTERVAL_W) - 1;
    localparam int PROD_W        = RATE_W + LEVEL_W;
    localparam int V_W           = PROD_W + 1;

    // shared divider widths
    localparam int DIV_NW = (SUM_W + LEVEL_SHIFT > 26) ? SUM_W + LEVEL_SHIFT : 26;
    localparam int DIV_DW = 24;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    // input queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCED_ON_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_HIGH     = 3'd5;

    // register reset values
    localparam logic [SAMPLE_W-1:0] RST_THROTTLE_LOW  = 10'd260;
    localparam logic [SAMPLE_W-1:0] RST_THROTTLE_HIGH = 10'd802;
    localparam logic [LEVEL_W-1:0]  RST_ACTIVE_LEVEL  = 11'd10;
    localparam logic [FORCED_W-1:0] RST_FORCED_ON_MS  = 16'd1000;
    localparam logic [RATE_W-1:0]   RST_RATE_LOW      = 12'd60;
    localparam logic [RATE_W-1:0]   RST_RATE_HIGH     = 12'd720;

    typedef struct packed {
        logic [SAMPLE_W-1:0] throttle_low;
        logic [SAMPLE_W-1:0] throttle_high;
        logic [LEVEL_W-1:0]  active_level;
        logic [FORCED_W-1:0] forced_on_ms;
        logic [RATE_W-1:0]   rate_low;
        logic [RATE_W-1:0]   rate_high;
    } t_cfg;

    // one classified tick as queued between front and back
    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [SUM_W-1:0]  sum;
        logic              rotor_q;
    } t_tick;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
        logic [DIV_DW-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ hdl/tpdc_fifo.sv @@
// ----------------------------------------------------------------------------
// tpdc_fifo: short tick queue
// Register-based FIFO that decouples the window front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tpdc_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  tpdc_pkg::t_tick      i_tick,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_empty,
    output tpdc_pkg::t_tick      o_head
);
    import tpdc_pkg::*;

    t_tick                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_CW-1:0]  r_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("tick pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("tick popped from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

@@ hdl/tpdc_div.sv @@
// ----------------------------------------------------------------------------
// tpdc_div: shared iterative divider
// Restoring division, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module tpdc_div (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  tpdc_pkg::t_div_req   i_req,
    output tpdc_pkg::t_div_rsp   o_rsp
);
    import tpdc_pkg::*;

    logic [DIV_NW-1:0] r_num;     // dividend shifting out, quotient shifting in
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_DW:0]   rem_sh;
    logic              ge;
    logic [DIV_DW:0]   rem_sub;

    assign rem_sh  = {r_rem, r_num[DIV_NW-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NW-2:0], ge};
            r_rem <= ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
    assign o_rsp.rem  = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy))
        else $error("divider done without a running division");

endmodule

`default_nettype wire

@@ hdl/tpdc_front.sv @@
// ----------------------------------------------------------------------------
// tpdc_front: tick front end
// Accepts ticks, runs the throttle moving-sum and rotor qualification
// windows, and queues the classified tick for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tpdc_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire  [tpdc_pkg::TIME_W-1:0]        i_time_ms,
    input  wire  [tpdc_pkg::SAMPLE_W-1:0]      i_throttle_sample,
    input  wire                                i_rotor_pin,
    input  wire                                i_q_full,
    output logic                               o_push,
    output tpdc_pkg::t_tick                    o_tick
);
    import tpdc_pkg::*;

    logic [SAMPLE_W-1:0] r_thr_win [THROTTLE_TAPS];
    logic [THR_AW-1:0]   r_thr_idx;
    logic [SUM_W-1:0]    r_thr_sum;
    logic [ROTOR_TAPS-1:0] r_rot_win;
    logic [ROT_AW-1:0]   r_rot_idx;
    logic [ROT_CW-1:0]   r_rot_cnt;
    logic                r_rot_q;

    logic [SUM_W-1:0]    n_thr_sum;
    logic [ROT_CW-1:0]   n_rot_cnt;
    logic                n_rot_q;
    logic                accept;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept;

    // oldest entry leaves, new one enters
    assign n_thr_sum = r_thr_sum - SUM_W'(r_thr_win[r_thr_idx]) + SUM_W'(i_throttle_sample);
    assign n_rot_cnt = r_rot_cnt - ROT_CW'(r_rot_win[r_rot_idx]) + ROT_CW'(i_rotor_pin);

    always_comb begin
        n_rot_q = r_rot_q;
        if (n_rot_cnt == ROT_CW'(ROTOR_TAPS)) begin
            n_rot_q = 1'b1;
        end else if (n_rot_cnt == '0) begin
            n_rot_q = 1'b0;
        end
    end

    assign o_tick.time_ms = i_time_ms;
    assign o_tick.sum     = n_thr_sum;
    assign o_tick.rotor_q = n_rot_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < THROTTLE_TAPS; i++) begin
                r_thr_win[i] <= '0;
            end
            r_thr_idx <= '0;
            r_thr_sum <= '0;
            r_rot_win <= '0;
            r_rot_idx <= '0;
            r_rot_cnt <= '0;
            r_rot_q   <= 1'b0;
        end else if (accept) begin
            r_thr_win[r_thr_idx] <= i_throttle_sample;
            r_thr_idx <= (r_thr_idx == THR_AW'(THROTTLE_TAPS - 1)) ? '0 : r_thr_idx + 1'b1;
            r_thr_sum <= n_thr_sum;
            r_rot_win[r_rot_idx] <= i_rotor_pin;
            r_rot_idx <= (r_rot_idx == ROT_AW'(ROTOR_TAPS - 1)) ? '0 : r_rot_idx + 1'b1;
            r_rot_cnt <= n_rot_cnt;
            r_rot_q   <= n_rot_q;
        end
    end

    a_rot_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rot_cnt == ROT_CW'($countones(r_rot_win)))
        else $error("rotor count out of step with window");

endmodule

`default_nettype wire

@@ hdl/tpdc_back.sv @@
// ----------------------------------------------------------------------------
// tpdc_back: drive back end
// Scales the throttle level, works out the pulse intervals on the shared
// divider, runs the drive state and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpdc_back (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  tpdc_pkg::t_cfg                     i_cfg,
    input  wire                                i_q_empty,
    output logic                               o_q_pop,
    input  tpdc_pkg::t_tick                    i_q_head,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic                               o_drive_on,
    output logic [tpdc_pkg::LEVEL_W-1:0]       o_throttle_level,
    output logic                               o_rotor_state,
    output logic [tpdc_pkg::INTERVAL_W-1:0]    o_pulse_interval_ms
);
    import tpdc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRE   = 3'd1;
    localparam logic [2:0] ST_LWAIT = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;
    localparam logic [2:0] ST_IWAIT = 3'd5;
    localparam logic [2:0] ST_DRIVE = 3'd6;

    logic [2:0]            r_state;
    t_tick                 r_item;
    logic [LEVEL_W-1:0]    r_level;
    logic [PROD_W-1:0]     r_pa;
    logic [PROD_W-1:0]     r_pb;
    logic [DIV_DW-1:0]     r_den;
    logic [INTERVAL_W-1:0] r_ion;
    logic [INTERVAL_W-1:0] r_ioff;
    logic [TIME_W-1:0]     r_last;
    logic                  r_drive;

    logic                  r_out_valid;
    logic                  r_out_drive;
    logic [LEVEL_W-1:0]    r_out_level;
    logic                  r_out_rotor;
    logic [INTERVAL_W-1:0] r_out_interval;

    t_div_req              div_req;
    t_div_rsp              div_rsp;

    logic [SUM_W-1:0]      base;
    logic [SUM_W-1:0]      span;
    logic [SUM_W-1:0]      excess;
    logic [V_W-1:0]        v_sum;
    logic [V_W+1:0]        den3;
    logic [DIV_DW:0]       rem2;
    logic [DIV_NW:0]       q2;
    logic                  slot_free;

    logic [TIME_W-1:0]     elapsed1;
    logic [TIME_W-1:0]     elapsed2;
    logic [TIME_W-1:0]     last1;
    logic                  drive1;
    logic [INTERVAL_W-1:0] iv;
    logic [TIME_W-1:0]     n_last;
    logic                  n_drive;

    tpdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign base   = SUM_W'(THROTTLE_TAPS) * SUM_W'(i_cfg.throttle_low);
    assign span   = SUM_W'(THROTTLE_TAPS)
                  * SUM_W'(i_cfg.throttle_high - i_cfg.throttle_low);
    assign excess = r_item.sum - base;
    assign v_sum  = V_W'(r_pa) + V_W'(r_pb);
    assign den3   = (V_W + 2)'(v_sum) + ((V_W + 2)'(v_sum) << 1);
    // floor(2N/D) = 2*floor(N/D) + (2*rem >= D)
    assign rem2   = {div_rsp.rem, 1'b0};
    assign q2     = {div_rsp.quot, (rem2 >= {1'b0, r_den})};

    assign slot_free = !r_out_valid || !i_stall;
    assign o_q_pop   = (r_state == ST_IDLE) && !i_q_empty;

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = DIV_NW'({excess, {LEVEL_SHIFT{1'b0}}});
        div_req.den   = DIV_DW'(span);
        case (r_state)
            ST_PRE: begin
                div_req.start = (r_item.sum > base)
                             && (i_cfg.throttle_high > i_cfg.throttle_low);
            end
            ST_SUM: begin
                div_req.start = (v_sum != '0);
                div_req.num   = DIV_NW'(INTERVAL_NUM);
                div_req.den   = den3[DIV_DW-1:0];
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // pulse mode: forced-on check, then toggle check against the interval
    // for the drive state at that point; below the active level the drive follows the rotor
    always_comb begin
        elapsed1 = r_item.time_ms - r_last;
        if (elapsed1 >= TIME_W'(i_cfg.forced_on_ms)) begin
            last1  = r_item.time_ms;
            drive1 = 1'b1;
        end else begin
            last1  = r_last;
            drive1 = r_drive;
        end
        iv       = drive1 ? r_ion : r_ioff;
        elapsed2 = r_item.time_ms - last1;
        if (r_level < i_cfg.active_level) begin
            n_last  = r_last;
            n_drive = r_item.rotor_q;
        end else if (elapsed2 >= TIME_W'(iv)) begin
            n_last  = r_item.time_ms;
            n_drive = !drive1;
        end else begin
            n_last  = last1;
            n_drive = drive1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    r_item <= i_q_head;
                end
            end
            ST_PRE: begin
                if (r_item.sum <= base) begin
                    r_level <= '0;
                end else begin
                    r_level <= LEVEL_W'(LEVEL_MAX);
                end
            end
            ST_LWAIT: begin
                if (div_rsp.done) begin
                    r_level <= (div_rsp.quot > DIV_NW'(LEVEL_MAX))
                             ? LEVEL_W'(LEVEL_MAX) : div_rsp.quot[LEVEL_W-1:0];
                end
            end
            ST_MUL: begin
                r_pa <= PROD_W'(i_cfg.rate_low) * PROD_W'(LEVEL_W'(LEVEL_MAX) - r_level);
                r_pb <= PROD_W'(i_cfg.rate_high) * PROD_W'(r_level);
            end
            ST_SUM: begin
                r_den  <= den3[DIV_DW-1:0];
                r_ion  <= INTERVAL_W'(INTERVAL_MAX);
                r_ioff <= INTERVAL_W'(INTERVAL_MAX);
            end
            ST_IWAIT: begin
                if (div_rsp.done) begin
                    r_ion  <= (div_rsp.quot > DIV_NW'(INTERVAL_MAX))
                            ? INTERVAL_W'(INTERVAL_MAX) : div_rsp.quot[INTERVAL_W-1:0];
                    r_ioff <= (q2 > (DIV_NW + 1)'(INTERVAL_MAX))
                            ? INTERVAL_W'(INTERVAL_MAX) : q2[INTERVAL_W-1:0];
                end
            end
            default: begin
                r_level <= r_level;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DRIVE) && slot_free) begin
            r_out_drive    <= n_drive;
            r_out_level    <= r_level;
            r_out_rotor    <= r_item.rotor_q;
            r_out_interval <= n_drive ? r_ion : r_ioff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last      <= '0;
            r_drive     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result may replace one taken at the same edge
            if ((r_state == ST_DRIVE) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= ST_PRE;
                    end
                end
                ST_PRE: begin
                    r_state <= div_req.start ? ST_LWAIT : ST_MUL;
                end
                ST_LWAIT: begin
                    if (div_rsp.done) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_state <= div_req.start ? ST_IWAIT : ST_DRIVE;
                end
                ST_IWAIT: begin
                    if (div_rsp.done) begin
                        r_state <= ST_DRIVE;
                    end
                end
                ST_DRIVE: begin
                    if (slot_free) begin
                        r_last  <= n_last;
                        r_drive <= n_drive;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid             = r_out_valid;
    assign o_drive_on          = r_out_drive;
    assign o_throttle_level    = r_out_level;
    assign o_rotor_state       = r_out_rotor;
    assign o_pulse_interval_ms = r_out_interval;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_throttle_level <= LEVEL_W'(LEVEL_MAX)))
        else $error("throttle level above full scale");

    a_rotor_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_throttle_level < i_cfg.active_level)) |-> (o_drive_on == o_rotor_state))
        else $error("drive does not follow rotor below active level");

    a_drive_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_drive_on == r_drive))
        else $error("reported drive differs from drive state");

endmodule

`default_nettype wire

@@ hdl/throttle_pulse_drive_controller.sv @@
// ----------------------------------------------------------------------------
// throttle_pulse_drive_controller: throttle-driven pulse drive controller
// Top level: configuration registers, tick front end, tick queue and drive
// back end with its shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): one control tick per item, a
//   millisecond timestamp, a raw throttle sample and the rotor pin level.
//   The front end takes a tick in the cycle it is offered unless the two-entry
//   tick queue is full; both windows are updated at that edge.
//   Output channel (o_out_valid / i_out_stall): exactly one result item per
//   tick, in order: drive state, scaled throttle level, qualified rotor level
//   and the pulse interval for the present drive state.
//   Each tick passes up to twice through the shared one-bit-per-cycle divider
//   (level scaling, then pulse interval); a skipped division shortens the
//   tick. The back end takes the next tick from the queue only once the last
//   one has been handed to the output register.
//   A stalled output register holds its item; the back end then waits with
//   the next finished tick and the queue fills, after which o_in_stall rises.
//   Reset (i_rst_n low, synchronous) clears both windows, the drive state
//   and the switch timestamp, empties the queue and loads the register
//   defaults. Configuration writes (i_cfg_we) take effect at once; the user must
//   make them only while no tick is in flight, as the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module throttle_pulse_drive_controller (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration write port
    input  wire                                i_cfg_we,
    input  wire  [tpdc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [tpdc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // tick input
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire  [tpdc_pkg::TIME_W-1:0]        i_time_ms,
    input  wire  [tpdc_pkg::SAMPLE_W-1:0]      i_throttle_sample,
    input  wire                                i_rotor_pin,
    // result output
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic                               o_drive_on,
    output logic [tpdc_pkg::LEVEL_W-1:0]       o_throttle_level,
    output logic                               o_rotor_state,
    output logic [tpdc_pkg::INTERVAL_W-1:0]    o_pulse_interval_ms
);
    import tpdc_pkg::*;

    t_cfg  r_cfg;

    // front to queue
    logic  push;
    t_tick push_tick;
    logic  q_full;
    // queue to back
    logic  q_empty;
    logic  q_pop;
    t_tick q_head;

    // register file; writes beyond the list fall through and are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.throttle_low  <= RST_THROTTLE_LOW;
            r_cfg.throttle_high <= RST_THROTTLE_HIGH;
            r_cfg.active_level  <= RST_ACTIVE_LEVEL;
            r_cfg.forced_on_ms  <= RST_FORCED_ON_MS;
            r_cfg.rate_low      <= RST_RATE_LOW;
            r_cfg.rate_high     <= RST_RATE_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THROTTLE_LOW:  r_cfg.throttle_low  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_THROTTLE_HIGH: r_cfg.throttle_high <= i_cfg_data[SAMPLE_W-1:0];
                CFG_ACTIVE_LEVEL:  r_cfg.active_level  <= i_cfg_data[LEVEL_W-1:0];
                CFG_FORCED_ON_MS:  r_cfg.forced_on_ms  <= i_cfg_data[FORCED_W-1:0];
                CFG_RATE_LOW:      r_cfg.rate_low      <= i_cfg_data[RATE_W-1:0];
                CFG_RATE_HIGH:     r_cfg.rate_high     <= i_cfg_data[RATE_W-1:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    // windows and tick classification
    tpdc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_in_valid),
        .o_stall           (o_in_stall),
        .i_time_ms         (i_time_ms),
        .i_throttle_sample (i_throttle_sample),
        .i_rotor_pin       (i_rotor_pin),
        .i_q_full          (q_full),
        .o_push            (push),
        .o_tick            (push_tick)
    );

    // decouples tick intake from the multi-cycle back end
    tpdc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tick  (push_tick),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // level scaling, intervals, drive state, result register
    tpdc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_q_empty           (q_empty),
        .o_q_pop             (q_pop),
        .i_q_head            (q_head),
        .o_valid             (o_out_valid),
        .i_stall             (i_out_stall),
        .o_drive_on          (o_drive_on),
        .o_throttle_level    (o_throttle_level),
        .o_rotor_state       (o_rotor_state),
        .o_pulse_interval_ms (o_pulse_interval_ms)
    );

endmodule

`default_nettype wire
